/* rtl/srm_pkg.sv */
// ----------------------------------------------------------------------------
// srm_pkg
// Shared types and constants for the call-sequence unlock and rate monitor.
// ----------------------------------------------------------------------------
package srm_pkg;

   localparam int ID_BITS         = 9;
   localparam int RULE_COUNT      = 4;
   localparam int UNLOCK_DEPTH    = 8;
   localparam int RING_DEPTH      = 16;
   localparam int STAMP_BITS      = 32;
   localparam int MAXC_BITS       = 4;

   localparam int RULE_IDX_BITS   = 2;
   localparam int RULE_BITS       = ID_BITS + 1 + MAXC_BITS;
   localparam int IDS_BITS        = 4 * ID_BITS;
   localparam int LEN_BITS        = 4;
   localparam int UNLOCK_IDX_BITS = $clog2(UNLOCK_DEPTH);
   localparam int COUNT_BITS      = $clog2(UNLOCK_DEPTH + 1);
   localparam int SLOT_BITS       = $clog2(RING_DEPTH);
   localparam int FILL_BITS       = $clog2(RING_DEPTH + 1);
   localparam int MEM_DEPTH       = RULE_COUNT * RING_DEPTH;
   localparam int MEM_ADDR_BITS   = RULE_IDX_BITS + SLOT_BITS;

   localparam int CSR_INDEX_BITS  = 4;
   localparam int CSR_DATA_BITS   = 36;
   localparam logic [STAMP_BITS-1:0] WINDOW_RESET = 32'd1000000;

   localparam int Q_DEPTH         = 2;
   localparam int Q_PTR_BITS      = 1;
   localparam int Q_COUNT_BITS    = 2;

   // register map
   localparam logic [CSR_INDEX_BITS-1:0] CSR_UNLOCK_LEN = 4'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDS_LOW    = 4'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_IDS_HIGH   = 4'd6;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_WINDOW     = 4'd7;

   typedef struct packed {
      logic [ID_BITS-1:0]    call_id;
      logic [STAMP_BITS-1:0] stamp;
   } req_type;

   typedef struct packed {
      logic                     unlocked;
      logic                     just_unlocked;
      logic                     rule_hit;
      logic [RULE_IDX_BITS-1:0] rule_index;
      logic                     violation;
      logic [FILL_BITS-1:0]     window_count;
   } rsp_type;

   // classified event handed from front to back
   typedef struct packed {
      logic                     unlocked;
      logic                     just_unlocked;
      logic                     rule_hit;
      logic [RULE_IDX_BITS-1:0] rule_index;
      logic [MAXC_BITS-1:0]     call_cap;
      logic [STAMP_BITS-1:0]    stamp;
   } cmd_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_WRITE,
      BK_PRIME,
      BK_EVICT,
      BK_EMIT
   } back_state_type;

endpackage

/* rtl/srm_front.sv */
// ----------------------------------------------------------------------------
// srm_front
// Register file, unlock sequence tracking and rule lookup for each event.
// ----------------------------------------------------------------------------
module srm_front (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [srm_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  logic [srm_pkg::CSR_DATA_BITS-1:0]    csr_data,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  srm_pkg::req_type                     req_data,
   output logic                                 push_valid,
   input  logic                                 push_ready,
   output srm_pkg::cmd_type                     push_cmd,
   output logic [srm_pkg::STAMP_BITS-1:0]       window_ticks
);
   import srm_pkg::*;

   logic [RULE_BITS-1:0]    rule_ff [RULE_COUNT];
   logic [LEN_BITS-1:0]     unlock_len_ff;
   logic [IDS_BITS-1:0]     ids_low_ff;
   logic [IDS_BITS-1:0]     ids_high_ff;
   logic [STAMP_BITS-1:0]   window_ff;

   logic [ID_BITS-1:0]      recent_ids_ff [UNLOCK_DEPTH];
   logic [ID_BITS-1:0]      recent_ids_in [UNLOCK_DEPTH];
   logic [COUNT_BITS-1:0]   recent_count_ff;
   logic [COUNT_BITS-1:0]   recent_count_in;
   logic                    active_ff;

   logic [2*IDS_BITS-1:0]   seq_all;
   logic [LEN_BITS-1:0]     len;
   logic [LEN_BITS-1:0]     j;
   logic                    seq_ok;
   logic                    starts_active;
   logic                    found;
   logic [RULE_IDX_BITS-1:0] rule_sel;
   logic                    accept;

   assign csr_ready    = 1'b1;
   assign req_ready    = push_ready;
   assign push_valid   = req_valid;
   assign accept       = req_valid && push_ready;
   assign window_ticks = window_ff;

   always_comb begin
      seq_all = {ids_high_ff, ids_low_ff};
      len = (unlock_len_ff > LEN_BITS'(UNLOCK_DEPTH)) ? LEN_BITS'(UNLOCK_DEPTH) : unlock_len_ff;
      starts_active = active_ff || (len == '0);

      recent_ids_in[0] = req_data.call_id;
      for (int i = 1; i < UNLOCK_DEPTH; i++) begin
         recent_ids_in[i] = recent_ids_ff[i-1];
      end
      recent_count_in = (recent_count_ff < COUNT_BITS'(UNLOCK_DEPTH)) ?
                        recent_count_ff + 1'b1 : recent_count_ff;

      seq_ok = (LEN_BITS'(recent_count_in) >= len);
      j      = '0;
      for (int i = 0; i < UNLOCK_DEPTH; i++) begin
         j = len - LEN_BITS'(i) - 1'b1;
         if ((LEN_BITS'(i) < len) &&
             (seq_all[i*ID_BITS +: ID_BITS] != recent_ids_in[j[UNLOCK_IDX_BITS-1:0]])) begin
            seq_ok = 1'b0;
         end
      end

      found    = 1'b0;
      rule_sel = '0;
      for (int r = 0; r < RULE_COUNT; r++) begin
         if (!found && rule_ff[r][ID_BITS] && (rule_ff[r][ID_BITS-1:0] == req_data.call_id)) begin
            found    = 1'b1;
            rule_sel = RULE_IDX_BITS'(r);
         end
      end

      push_cmd.stamp    = req_data.stamp;
      push_cmd.call_cap = rule_ff[rule_sel][ID_BITS+MAXC_BITS:ID_BITS+1];
      if (starts_active) begin
         push_cmd.unlocked      = 1'b1;
         push_cmd.just_unlocked = 1'b0;
         push_cmd.rule_hit      = found;
         push_cmd.rule_index    = rule_sel;
      end else begin
         push_cmd.unlocked      = seq_ok;
         push_cmd.just_unlocked = seq_ok;
         push_cmd.rule_hit      = 1'b0;
         push_cmd.rule_index    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < RULE_COUNT; r++) begin
            rule_ff[r] <= '0;
         end
         unlock_len_ff <= '0;
         ids_low_ff    <= '0;
         ids_high_ff   <= '0;
         window_ff     <= WINDOW_RESET;
      end else if (csr_valid) begin
         if (csr_index < CSR_INDEX_BITS'(RULE_COUNT)) begin
            rule_ff[csr_index[RULE_IDX_BITS-1:0]] <= csr_data[RULE_BITS-1:0];
         end else begin
            case (csr_index)
               CSR_UNLOCK_LEN: unlock_len_ff <= csr_data[LEN_BITS-1:0];
               CSR_IDS_LOW:    ids_low_ff    <= csr_data[IDS_BITS-1:0];
               CSR_IDS_HIGH:   ids_high_ff   <= csr_data[IDS_BITS-1:0];
               CSR_WINDOW:     window_ff     <= csr_data[STAMP_BITS-1:0];
               default:        ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < UNLOCK_DEPTH; i++) begin
            recent_ids_ff[i] <= '0;
         end
         recent_count_ff <= '0;
         active_ff       <= 1'b0;
      end else if (accept) begin
         if (starts_active) begin
            active_ff <= 1'b1;
         end else begin
            recent_ids_ff   <= recent_ids_in;
            recent_count_ff <= recent_count_in;
            active_ff       <= seq_ok;
         end
      end
   end

endmodule

/* rtl/srm_queue.sv */
// ----------------------------------------------------------------------------
// srm_queue
// Two-entry queue of classified events between front and back.
// ----------------------------------------------------------------------------
module srm_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push_valid,
   output logic             push_ready,
   input  srm_pkg::cmd_type push_cmd,
   output logic             pop_valid,
   input  logic             pop_ready,
   output srm_pkg::cmd_type pop_cmd
);
   import srm_pkg::*;

   cmd_type                 slot_ff [Q_DEPTH];
   logic [Q_PTR_BITS-1:0]   wr_ptr_ff;
   logic [Q_PTR_BITS-1:0]   rd_ptr_ff;
   logic [Q_COUNT_BITS-1:0] count_ff;
   logic                    do_push;
   logic                    do_pop;

   assign push_ready = (count_ff != Q_COUNT_BITS'(Q_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

endmodule

/* rtl/srm_back.sv */
// ----------------------------------------------------------------------------
// srm_back
// Per-rule timestamp rings, window eviction walk and result register.
// ----------------------------------------------------------------------------
module srm_back (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           pop_valid,
   output logic                           pop_ready,
   input  srm_pkg::cmd_type               pop_cmd,
   input  logic [srm_pkg::STAMP_BITS-1:0] window_ticks,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output srm_pkg::rsp_type               rsp_data
);
   import srm_pkg::*;

   logic [STAMP_BITS-1:0]    ring_mem [MEM_DEPTH];
   logic [STAMP_BITS-1:0]    rd_data_ff;

   back_state_type           state_ff;
   back_state_type           state_in;

   cmd_type                  cmd_ff;
   logic [SLOT_BITS-1:0]     head_ff [RULE_COUNT];
   logic [FILL_BITS-1:0]     fill_ff [RULE_COUNT];
   logic [SLOT_BITS-1:0]     cur_head_ff;
   logic [FILL_BITS-1:0]     cur_fill_ff;
   logic [SLOT_BITS-1:0]     cur_head_in;
   logic [FILL_BITS-1:0]     cur_fill_in;
   logic [SLOT_BITS-1:0]     wr_slot;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_next;

   logic [STAMP_BITS-1:0]    age;
   logic                     evict;
   logic                     out_free;
   logic                     mem_we;
   logic [MEM_ADDR_BITS-1:0] mem_wr_addr;
   logic [MEM_ADDR_BITS-1:0] mem_rd_addr;
   logic                     load_rsp;
   logic                     store_ring;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;
   assign out_free  = !rsp_valid_ff || rsp_ready;

   assign age   = cmd_ff.stamp - rd_data_ff;
   assign evict = (cur_fill_ff != '0) && (age > window_ticks);

   // slot for the new stamp; a full ring overwrites its oldest entry
   always_comb begin
      if (fill_ff[cmd_ff.rule_index] >= FILL_BITS'(RING_DEPTH)) begin
         wr_slot     = head_ff[cmd_ff.rule_index];
         cur_head_in = head_ff[cmd_ff.rule_index] + 1'b1;
         cur_fill_in = FILL_BITS'(RING_DEPTH);
      end else begin
         wr_slot     = head_ff[cmd_ff.rule_index] +
                       fill_ff[cmd_ff.rule_index][SLOT_BITS-1:0];
         cur_head_in = head_ff[cmd_ff.rule_index];
         cur_fill_in = fill_ff[cmd_ff.rule_index] + 1'b1;
      end
   end

   always_comb begin
      rsp_next.unlocked      = cmd_ff.unlocked;
      rsp_next.just_unlocked = cmd_ff.just_unlocked;
      rsp_next.rule_hit      = cmd_ff.rule_hit;
      rsp_next.rule_index    = cmd_ff.rule_hit ? cmd_ff.rule_index : '0;
      rsp_next.violation     = cmd_ff.rule_hit &&
                               (cur_fill_ff > FILL_BITS'(cmd_ff.call_cap));
      rsp_next.window_count  = cmd_ff.rule_hit ? cur_fill_ff : '0;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (pop_valid) begin
               state_in = pop_cmd.rule_hit ? BK_WRITE : BK_EMIT;
            end
         end
         BK_WRITE: state_in = BK_PRIME;
         BK_PRIME: state_in = BK_EVICT;
         BK_EVICT: begin
            if (!evict) begin
               state_in = BK_EMIT;
            end
         end
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default: state_in = BK_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop_ready   = 1'b0;
      mem_we      = 1'b0;
      load_rsp    = 1'b0;
      store_ring  = 1'b0;
      mem_wr_addr = {cmd_ff.rule_index, wr_slot};
      mem_rd_addr = {cmd_ff.rule_index, cur_head_ff};
      case (state_ff)
         BK_IDLE:  pop_ready = 1'b1;
         BK_WRITE: mem_we = 1'b1;
         BK_PRIME: mem_rd_addr = {cmd_ff.rule_index, cur_head_ff};
         BK_EVICT: begin
            // read one slot ahead so a run of evictions costs a beat each
            mem_rd_addr = {cmd_ff.rule_index, cur_head_ff + 1'b1};
            store_ring  = !evict;
         end
         BK_EMIT:  load_rsp = out_free;
         default:  ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[mem_wr_addr] <= cmd_ff.stamp;
      end
      rd_data_ff <= ring_mem[mem_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         cmd_ff <= pop_cmd;
      end
      if (state_ff == BK_WRITE) begin
         cur_head_ff <= cur_head_in;
         cur_fill_ff <= cur_fill_in;
      end else if ((state_ff == BK_EVICT) && evict) begin
         cur_head_ff <= cur_head_ff + 1'b1;
         cur_fill_ff <= cur_fill_ff - 1'b1;
      end
      if (load_rsp) begin
         rsp_data_ff <= rsp_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int r = 0; r < RULE_COUNT; r++) begin
            head_ff[r] <= '0;
            fill_ff[r] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (store_ring) begin
            head_ff[cmd_ff.rule_index] <= cur_head_ff;
            fill_ff[cmd_ff.rule_index] <= cur_fill_ff;
         end
      end
   end

endmodule

/* rtl/syscall_sequence_unlock_rate_monitor.sv */
// ----------------------------------------------------------------------------
// syscall_sequence_unlock_rate_monitor
// Call-sequence unlock with per-rule sliding-window rate monitoring.
// ----------------------------------------------------------------------------
// Channels: req_ takes one call event (call_id, stamp) per beat until the
// queue fills, rsp_ returns one result per event in order, csr_ writes the
// eight registers (index 0..7, always ready; write only while no event is
// in flight). The front classifies an event in the cycle it is accepted
// (unlock shift register, rule lookup) and queues it; the back runs the
// rule's ring. For a rule hit the back writes the stamp, primes a read and
// walks the evictions before it emits the result; other events go straight
// to emit. The back pops a new event only from idle, after the last result
// is loaded. Its eviction walk over ring memory takes one entry per cycle.
// The two-entry queue lets req_ take up to two more events while the back is
// busy. A stalled rsp_ holds its beat; the back waits to load the next one.
// Reset: registers go to their defaults (window 1000000 ticks, unlock length
// 0, events pass unlocked), all rings are empty. No clearing pass is needed.
// ----------------------------------------------------------------------------
module syscall_sequence_unlock_rate_monitor (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [srm_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [srm_pkg::CSR_DATA_BITS-1:0]  csr_data,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  srm_pkg::req_type                   req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output srm_pkg::rsp_type                   rsp_data
);
   import srm_pkg::*;

   logic                  push_valid;
   logic                  push_ready;
   cmd_type               push_cmd;
   logic                  pop_valid;
   logic                  pop_ready;
   cmd_type               pop_cmd;
   logic [STAMP_BITS-1:0] window_ticks;

   srm_front u_front (
      .clock        (clock),
      .reset        (reset),
      .csr_valid    (csr_valid),
      .csr_ready    (csr_ready),
      .csr_index    (csr_index),
      .csr_data     (csr_data),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_data     (req_data),
      .push_valid   (push_valid),
      .push_ready   (push_ready),
      .push_cmd     (push_cmd),
      .window_ticks (window_ticks)
   );

   srm_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   srm_back u_back (
      .clock        (clock),
      .reset        (reset),
      .pop_valid    (pop_valid),
      .pop_ready    (pop_ready),
      .pop_cmd      (pop_cmd),
      .window_ticks (window_ticks),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_data     (rsp_data)
   );

endmodule
